// ----- src/mrst_pkg.sv -----
// mrst_pkg: widths, command codes, multiplier request/response types and
// the fixed-point helper functions of the relu trainer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mrst_pkg;

    localparam int P_N_INPUTS = 3;
    localparam int P_N_HIDDEN = 4;

    localparam int W_CMD  = 2;
    localparam int W_FEAT = 11;
    localparam int W_TGT  = 16;
    localparam int W_IDX  = 5;
    localparam int W_PAR  = 48;
    localparam int W_PRED = 47;
    localparam int W_COST = 64;
    localparam int W_RATE = 6;

    localparam logic [W_RATE-1:0] RATE_RESET = 6'd27;

    localparam logic [W_CMD-1:0] CMD_INFER = 2'd0;
    localparam logic [W_CMD-1:0] CMD_TRAIN = 2'd1;
    localparam logic [W_CMD-1:0] CMD_WRITE = 2'd2;
    localparam logic [W_CMD-1:0] CMD_NONE  = 2'd3;

    localparam logic signed [63:0] SAT_HI = 64'sd140737488355327;
    localparam logic signed [63:0] SAT_LO = -64'sd140737488355328;
    localparam logic [63:0] STEP_MAX = 64'h0002_0000_0000_0000;
    localparam logic [63:0] MAG_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic        start;
        logic        neg;
        logic [63:0] a;
        logic [63:0] b;
    } t_mul_req;

    typedef struct packed {
        logic               done;
        logic [63:0]        umag;
        logic signed [63:0] sval;
    } t_mul_rsp;

    function automatic logic [63:0] f_mag(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic signed [47:0] f_sat48(input logic signed [63:0] v);
        logic signed [47:0] r;
        if (v > SAT_HI) r = SAT_HI[47:0];
        else if (v < SAT_LO) r = SAT_LO[47:0];
        else r = v[47:0];
        return r;
    endfunction

    // w minus (|g| >> rs with sign of g), step clamped to 2^49, saturated
    function automatic logic signed [47:0] f_step(
        input logic signed [47:0]       w,
        input logic signed [63:0]       g,
        input logic [W_RATE-1:0]        rs
    );
        logic [63:0]        m;
        logic [49:0]        mc;
        logic signed [51:0] s;
        logic signed [51:0] d;
        m  = f_mag(g) >> rs;
        mc = (m > STEP_MAX) ? STEP_MAX[49:0] : m[49:0];
        s  = g[63] ? -$signed({2'b00, mc}) : $signed({2'b00, mc});
        d  = {{4{w[47]}}, w} - s;
        return f_sat48({{12{d[51]}}, d});
    endfunction

endpackage

`default_nettype wire

// ----- src/mrst_ifs.sv -----
// mrst_in_if, mrst_res_if, mrst_cfg_if: valid/ready channels of the trainer
// depends on mrst_pkg
`timescale 1ns / 1ps
`default_nettype none

interface mrst_in_if import mrst_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [W_CMD-1:0]         command;
    logic signed [W_FEAT-1:0] feature_a;
    logic signed [W_FEAT-1:0] feature_b;
    logic signed [W_FEAT-1:0] feature_c;
    logic signed [W_TGT-1:0]  target_value;
    logic [W_IDX-1:0]         param_index;
    logic signed [W_PAR-1:0]  param_value;
    modport source (output valid, command, feature_a, feature_b, feature_c,
                    target_value, param_index, param_value, input ready);
    modport sink (input valid, command, feature_a, feature_b, feature_c,
                  target_value, param_index, param_value, output ready);
endinterface

interface mrst_res_if import mrst_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [W_PRED-1:0] prediction;
    logic [W_COST-1:0] cost;
    modport source (output valid, prediction, cost, input ready);
    modport sink (input valid, prediction, cost, output ready);
endinterface

interface mrst_cfg_if import mrst_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [W_RATE-1:0] rate_shift;
    modport source (output valid, rate_shift, input ready);
    modport sink (input valid, rate_shift, output ready);
endinterface

`default_nettype wire

// ----- src/mrst_smul.sv -----
// mrst_smul: bit-serial 64x64 magnitude multiplier, one multiplier bit a cycle,
// result scaled by 2^-32 with saturation; depends on mrst_pkg
`timescale 1ns / 1ps
`default_nettype none

module mrst_smul import mrst_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_mul_req i_req,
    output t_mul_rsp      o_rsp
);

    logic         r_busy;
    logic         r_done;
    logic [5:0]   r_cnt;
    logic         r_neg;
    logic [63:0]  r_a;
    logic [63:0]  r_b;
    logic [127:0] r_acc;
    logic [64:0]  n_sum;
    logic [63:0]  w_umag;
    logic [63:0]  w_smag;

    assign n_sum = {1'b0, r_acc[127:64]} + (r_b[0] ? {1'b0, r_a} : 65'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && !i_req.start && (r_cnt == 6'd63);
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_a    <= i_req.a;
                r_b    <= i_req.b;
                r_neg  <= i_req.neg;
                r_acc  <= '0;
            end else if (r_busy) begin
                r_acc <= {n_sum, r_acc[63:1]};
                r_b   <= r_b >> 1;
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign w_umag = (|r_acc[127:96]) ? '1 : r_acc[95:32];
    assign w_smag = w_umag[63] ? MAG_MAX : w_umag;

    assign o_rsp.done = r_done;
    assign o_rsp.umag = w_umag;
    assign o_rsp.sval = r_neg ? -$signed(w_smag) : $signed(w_smag);

endmodule

`default_nettype wire

// ----- src/mlp_relu_sgd_trainer_unit.sv -----
// mlp_relu_sgd_trainer_unit: relu network with one sgd step per train beat;
// write and unused commands go straight to the output register, and every
// product of infer and train goes through the one bit-serial multiplier
// one item at a time, next beat taken the cycle after the result is loaded;
// result waits in an output register while next is taken
// reset: synchronous, active low; all weights and biases zero, rate_shift 27
`timescale 1ns / 1ps
`default_nettype none

module mlp_relu_sgd_trainer_unit import mrst_pkg::*; #(
    parameter int N_INPUTS = P_N_INPUTS,
    parameter int N_HIDDEN = P_N_HIDDEN
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    mrst_in_if.sink   i_in,
    mrst_res_if.source o_res,
    mrst_cfg_if.sink  i_cfg
);

    localparam int NW = N_INPUTS * N_HIDDEN;
    localparam int JW = (N_HIDDEN > 1) ? $clog2(N_HIDDEN) : 1;
    localparam int KW = (N_INPUTS > 1) ? $clog2(N_INPUTS) : 1;
    localparam int WW = (NW > 1) ? $clog2(NW) : 1;

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_HMUL  = 4'd1;  // hidden products
    localparam logic [3:0] S_OMUL  = 4'd2;  // output products
    localparam logic [3:0] S_COST  = 4'd3;  // err squared
    localparam logic [3:0] S_DMUL  = 4'd4;  // hidden deltas from old output weights
    localparam logic [3:0] S_W2MUL = 4'd5;  // output weight gradients
    localparam logic [3:0] S_B2    = 4'd6;  // output bias step
    localparam logic [3:0] S_W1MUL = 4'd7;  // hidden weight gradients
    localparam logic [3:0] S_B1    = 4'd8;  // hidden bias step
    localparam logic [3:0] S_FIN   = 4'd9;  // hand result to output register

    logic [3:0] r_state;

    // network parameters
    logic signed [47:0] r_w1 [NW];
    logic signed [47:0] r_b1 [N_HIDDEN];
    logic signed [47:0] r_w2 [N_HIDDEN];
    logic signed [47:0] r_b2;
    logic [W_RATE-1:0]  r_rate;

    // per-item working state
    logic [W_CMD-1:0]         r_cmd;
    logic signed [W_FEAT-1:0] r_x [N_INPUTS];
    logic signed [W_TGT-1:0]  r_tgt;
    logic signed [47:0]       r_a1 [N_HIDDEN];
    logic signed [63:0]       r_d [N_HIDDEN];
    logic signed [63:0]       r_acc;
    logic signed [63:0]       r_err;
    logic signed [63:0]       r_g;
    logic [JW-1:0]            r_j;
    logic [KW-1:0]            r_k;
    logic                     r_start;
    logic                     n_start;
    logic [W_PRED-1:0]        r_pred_s;
    logic [W_COST-1:0]        r_cost_s;

    // output register
    logic              r_ov;
    logic [W_PRED-1:0] r_pred;
    logic [W_COST-1:0] r_cost;
    logic [W_CMD-1:0]  r_out_cmd;

    t_mul_req w_req;
    t_mul_rsp w_rsp;

    logic               w_klast;
    logic               w_jlast;
    logic [JW-1:0]      w_jn;
    logic [WW-1:0]      w_widx;
    logic signed [63:0] w_xfix;
    logic signed [47:0] w_o1j;
    logic signed [63:0] w_opa;
    logic signed [63:0] w_opb;
    logic signed [63:0] n_hsum;
    logic signed [47:0] w_psat;
    logic signed [63:0] n_osum;
    logic signed [47:0] w_a2;
    logic signed [47:0] w_o2;
    logic signed [63:0] w_err;
    logic               w_accept;
    logic               w_load;
    int                 w_idx;

    assign w_accept = i_in.valid && i_in.ready;
    assign w_idx    = int'(i_in.param_index);
    // output register takes the finished result when empty or being drained
    assign w_load   = (r_state == S_FIN) && (!r_ov || o_res.ready);

    assign w_klast = (int'(r_k) == N_INPUTS - 1);
    assign w_jlast = (int'(r_j) == N_HIDDEN - 1);
    assign w_jn    = r_j + JW'(1);
    assign w_widx  = WW'(int'(r_k) * N_HIDDEN + int'(r_j));
    // integer feature as fixed point with 32 fraction bits
    assign w_xfix  = {{21{r_x[r_k][W_FEAT-1]}}, r_x[r_k], 32'd0};
    assign w_o1j   = r_a1[r_j][47] ? 48'sd0 : r_a1[r_j];

    // operand select for the shared multiplier
    always_comb begin
        w_opa = '0;
        w_opb = '0;
        case (r_state)
            S_HMUL: begin
                w_opa = w_xfix;
                w_opb = {{16{r_w1[w_widx][47]}}, r_w1[w_widx]};
            end
            S_OMUL: begin
                w_opa = {{16{w_o1j[47]}}, w_o1j};
                w_opb = {{16{r_w2[r_j][47]}}, r_w2[r_j]};
            end
            S_COST: begin
                w_opa = r_err;
                w_opb = r_err;
            end
            S_DMUL: begin
                w_opa = r_g;
                w_opb = {{16{r_w2[r_j][47]}}, r_w2[r_j]};
            end
            S_W2MUL: begin
                w_opa = r_g;
                w_opb = {{16{w_o1j[47]}}, w_o1j};
            end
            S_W1MUL: begin
                w_opa = r_d[r_j];
                w_opb = w_xfix;
            end
            default: begin
                w_opa = '0;
                w_opb = '0;
            end
        endcase
    end

    // launch of the next product: r_start registers the request of the state that asks for it
    always_comb begin
        n_start = 1'b0;
        unique case (r_state) inside
            S_IDLE:  n_start = w_accept && (i_in.command != CMD_WRITE)
                               && (i_in.command != CMD_NONE);
            S_HMUL, S_COST, S_DMUL: n_start = w_rsp.done;
            S_OMUL:  n_start = w_rsp.done && (!w_jlast || (r_cmd == CMD_TRAIN));
            S_W2MUL: n_start = w_rsp.done && !w_jlast;
            S_B2:    n_start = 1'b1;
            S_W1MUL: n_start = w_rsp.done && !w_klast;
            S_B1:    n_start = !w_jlast;
            default: n_start = 1'b0;
        endcase
    end

    assign w_req.start = r_start;
    assign w_req.neg   = w_opa[63] ^ w_opb[63];
    assign w_req.a     = f_mag(w_opa);
    assign w_req.b     = f_mag(w_opb);

    mrst_smul u_smul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign n_hsum = r_acc + w_rsp.sval;
    assign w_psat = f_sat48(w_rsp.sval);
    assign n_osum = r_acc + {{16{w_psat[47]}}, w_psat};
    assign w_a2   = f_sat48(n_osum);
    assign w_o2   = w_a2[47] ? 48'sd0 : w_a2;
    assign w_err  = {{16{w_o2[47]}}, w_o2} - {{16{r_tgt[W_TGT-1]}}, r_tgt, 32'd0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_start <= 1'b0;
            r_ov    <= 1'b0;
            r_rate  <= RATE_RESET;
            r_b2    <= '0;
            for (int i = 0; i < NW; i++) r_w1[i] <= '0;
            for (int i = 0; i < N_HIDDEN; i++) begin
                r_b1[i] <= '0;
                r_w2[i] <= '0;
            end
        end else begin
            r_start <= n_start;
            if (i_cfg.valid && i_cfg.ready) r_rate <= i_cfg.rate_shift;
            if (w_load) r_ov <= 1'b1;
            else if (o_res.valid && o_res.ready) r_ov <= 1'b0;

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_cmd    <= i_in.command;
                        r_tgt    <= i_in.target_value;
                        r_pred_s <= '0;
                        r_cost_s <= '0;
                        for (int k = 0; k < N_INPUTS; k++) begin
                            // inputs past the third read as zero
                            r_x[k] <= (k == 0) ? i_in.feature_a :
                                      (k == 1) ? i_in.feature_b :
                                      (k == 2) ? i_in.feature_c : '0;
                        end
                        r_j   <= '0;
                        r_k   <= '0;
                        r_acc <= {{16{r_b1[0][47]}}, r_b1[0]};
                        if (i_in.command == CMD_WRITE) begin
                            // out-of-range index is dropped
                            if (w_idx < NW)
                                r_w1[WW'(w_idx)] <= i_in.param_value;
                            else if (w_idx < NW + N_HIDDEN)
                                r_b1[JW'(w_idx - NW)] <= i_in.param_value;
                            else if (w_idx < NW + 2 * N_HIDDEN)
                                r_w2[JW'(w_idx - NW - N_HIDDEN)] <= i_in.param_value;
                            else if (w_idx == NW + 2 * N_HIDDEN)
                                r_b2 <= i_in.param_value;
                            r_state <= S_FIN;
                        end else if (i_in.command == CMD_NONE) begin
                            r_state <= S_FIN;
                        end else begin
                            r_state <= S_HMUL;
                        end
                    end
                end
                S_HMUL: begin
                    if (w_rsp.done) begin
                        if (w_klast) begin
                            r_a1[r_j] <= f_sat48(n_hsum);
                            r_k       <= '0;
                            if (w_jlast) begin
                                r_j     <= '0;
                                r_acc   <= {{16{r_b2[47]}}, r_b2};
                                r_state <= S_OMUL;
                            end else begin
                                r_j   <= w_jn;
                                r_acc <= {{16{r_b1[w_jn][47]}}, r_b1[w_jn]};
                            end
                        end else begin
                            r_k   <= r_k + KW'(1);
                            r_acc <= n_hsum;
                        end
                    end
                end
                S_OMUL: begin
                    if (w_rsp.done) begin
                        if (w_jlast) begin
                            r_pred_s <= w_o2[W_PRED-1:0];
                            r_err    <= w_err;
                            // zero gradient when output relu is off
                            r_g      <= w_a2[47] ? 64'sd0 : (w_err <<< 1);
                            r_j      <= '0;
                            if (r_cmd == CMD_TRAIN) begin
                                r_state <= S_COST;
                            end else begin
                                r_state <= S_FIN;
                            end
                        end else begin
                            r_acc   <= n_osum;
                            r_j     <= w_jn;
                        end
                    end
                end
                S_COST: begin
                    if (w_rsp.done) begin
                        r_cost_s <= w_rsp.umag;
                        r_state  <= S_DMUL;
                    end
                end
                S_DMUL: begin
                    if (w_rsp.done) begin
                        r_d[r_j] <= r_a1[r_j][47] ? 64'sd0 : w_rsp.sval;
                        if (w_jlast) begin
                            r_j     <= '0;
                            r_state <= S_W2MUL;
                        end else begin
                            r_j <= w_jn;
                        end
                    end
                end
                S_W2MUL: begin
                    if (w_rsp.done) begin
                        r_w2[r_j] <= f_step(r_w2[r_j], w_rsp.sval, r_rate);
                        if (w_jlast) begin
                            r_j     <= '0;
                            r_state <= S_B2;
                        end else begin
                            r_j     <= w_jn;
                        end
                    end
                end
                S_B2: begin
                    r_b2    <= f_step(r_b2, r_g, r_rate);
                    r_k     <= '0;
                    r_state <= S_W1MUL;
                end
                S_W1MUL: begin
                    if (w_rsp.done) begin
                        r_w1[w_widx] <= f_step(r_w1[w_widx], w_rsp.sval, r_rate);
                        if (w_klast) begin
                            r_state <= S_B1;
                        end else begin
                            r_k     <= r_k + KW'(1);
                        end
                    end
                end
                S_B1: begin
                    // each hidden bias moves once per step
                    r_b1[r_j] <= f_step(r_b1[r_j], r_d[r_j], r_rate);
                    r_k       <= '0;
                    if (w_jlast) begin
                        r_state <= S_FIN;
                    end else begin
                        r_j     <= w_jn;
                        r_state <= S_W1MUL;
                    end
                end
                S_FIN: begin
                    if (w_load) begin
                        r_pred    <= r_pred_s;
                        r_cost    <= r_cost_s;
                        r_out_cmd <= r_cmd;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready       = (r_state == S_IDLE);
    assign i_cfg.ready      = 1'b1;
    assign o_res.valid      = r_ov;
    assign o_res.prediction = r_pred;
    assign o_res.cost       = r_cost;

    // a product never completes in the cycle right after it was launched
    a_mul_launch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_start |=> !w_rsp.done)
        else $error("multiplier done right after start");

    // only a train beat carries a nonzero cost
    a_cost_train: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (o_res.cost != '0)) |-> (r_out_cmd == CMD_TRAIN))
        else $error("nonzero cost on non-train beat");

    // an accepted beat always leaves idle
    a_leave_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != S_IDLE))
        else $error("sequencer stayed idle after accept");

endmodule

`default_nettype wire

// ----- dv/mlp_relu_sgd_trainer_unit_tb.sv -----
// mlp_relu_sgd_trainer_unit_tb: self-checking bench for the relu sgd trainer,
// with a bit-accurate predictor of the network and a scoreboard class
// depends on mrst_pkg, mrst_ifs and the trainer top level
`timescale 1ns / 1ps

module mlp_relu_sgd_trainer_unit_tb;
    import mrst_pkg::*;

    typedef struct {
        logic [W_CMD-1:0]         command;
        logic signed [W_FEAT-1:0] fa;
        logic signed [W_FEAT-1:0] fb;
        logic signed [W_FEAT-1:0] fc;
        logic signed [W_TGT-1:0]  target;
        logic [W_IDX-1:0]         pidx;
        logic signed [W_PAR-1:0]  pval;
    } t_beat;

    typedef struct {
        logic [W_PRED-1:0] prediction;
        logic [W_COST-1:0] cost;
    } t_outcome;

    // network model: weights, biases and the learning rate shift
    class trainer_scoreboard;
        logic signed [63:0] hw[12];
        logic signed [63:0] hb[4];
        logic signed [63:0] ow[4];
        logic signed [63:0] ob;
        logic [5:0]         rshift;
        t_outcome           pending[$];
        int                 errors;

        function void clear();
            foreach (hw[i]) hw[i] = 0;
            foreach (hb[i]) begin
                hb[i] = 0;
                ow[i] = 0;
            end
            ob = 0;
            rshift = RATE_RESET;
            errors = 0;
        endfunction

        function logic signed [63:0] clip48(logic signed [63:0] v);
            if (v > SAT_HI) return SAT_HI;
            if (v < SAT_LO) return SAT_LO;
            return v;
        endfunction

        function logic [63:0] absval(logic signed [63:0] v);
            return v[63] ? -v : v;
        endfunction

        // (a*b)>>32 unsigned, saturated to all ones
        function logic [63:0] umul(logic [63:0] a, logic [63:0] b);
            logic [127:0] p;
            p = {64'd0, a} * {64'd0, b};
            if (p[127:96] != 0) return '1;
            return p[95:32];
        endfunction

        function logic signed [63:0] smul(logic signed [63:0] a, logic signed [63:0] b);
            logic [63:0] r;
            r = umul(absval(a), absval(b));
            if (r > MAG_MAX) r = MAG_MAX;
            return (a[63] != b[63]) ? -$signed(r) : $signed(r);
        endfunction

        function logic signed [63:0] descend(logic signed [63:0] w,
                                             logic signed [63:0] g);
            logic [63:0]        r;
            logic signed [63:0] s;
            r = absval(g) >> rshift;
            if (r > MAG_MAX) r = MAG_MAX;
            s = g[63] ? -$signed(r) : $signed(r);
            if (s > 64'sh2_0000_0000_0000) s = 64'sh2_0000_0000_0000;
            if (s < -64'sh2_0000_0000_0000) s = -64'sh2_0000_0000_0000;
            return clip48(w - s);
        endfunction

        function void note_beat(t_beat b);
            t_outcome           o;
            logic signed [63:0] x[3], a1[4], o1[4], d[4];
            logic signed [63:0] acc, a2, o2, err, g;
            o.prediction = 0;
            o.cost = 0;
            if (b.command == CMD_WRITE) begin
                if (b.pidx < 12) hw[b.pidx] = b.pval;
                else if (b.pidx < 16) hb[b.pidx - 12] = b.pval;
                else if (b.pidx < 20) ow[b.pidx - 16] = b.pval;
                else if (b.pidx == 20) ob = b.pval;
            end else if (b.command != CMD_NONE) begin
                x[0] = b.fa;
                x[1] = b.fb;
                x[2] = b.fc;
                for (int j = 0; j < 4; j++) begin
                    acc = hb[j];
                    for (int k = 0; k < 3; k++) acc += x[k] * hw[k*4+j];
                    a1[j] = clip48(acc);
                    o1[j] = a1[j] < 0 ? 0 : a1[j];
                end
                acc = ob;
                for (int j = 0; j < 4; j++) acc += clip48(smul(o1[j], ow[j]));
                a2 = clip48(acc);
                o2 = a2 < 0 ? 0 : a2;
                o.prediction = o2[46:0];
                if (b.command == CMD_TRAIN) begin
                    err = o2 - (64'(b.target) <<< 32);
                    g = a2 >= 0 ? 2 * err : 0;
                    o.cost = umul(absval(err), absval(err));
                    for (int j = 0; j < 4; j++) d[j] = a1[j] >= 0 ? smul(g, ow[j]) : 0;
                    for (int j = 0; j < 4; j++) ow[j] = descend(ow[j], smul(g, o1[j]));
                    ob = descend(ob, g);
                    for (int j = 0; j < 4; j++) begin
                        for (int k = 0; k < 3; k++)
                            hw[k*4+j] = descend(hw[k*4+j], smul(d[j], x[k] <<< 32));
                        hb[j] = descend(hb[j], d[j]);
                    end
                end
            end
            pending.push_back(o);
        endfunction

        function void check_result(logic [W_PRED-1:0] p, logic [W_COST-1:0] c);
            t_outcome e;
            if (pending.size() == 0) begin
                $error("result with none expected: prediction %h", p);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (p !== e.prediction) begin
                $error("prediction exp %h got %h", e.prediction, p);
                errors++;
            end
            if (c !== e.cost) begin
                $error("cost exp %h got %h", e.cost, c);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    mrst_in_if  in_ch ();
    mrst_res_if res_ch ();
    mrst_cfg_if cfg_ch ();

    mlp_relu_sgd_trainer_unit u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in(in_ch.sink), .o_res(res_ch.source), .i_cfg(cfg_ch.sink)
    );

    always begin
        #6 i_clk = 1;
        #6 i_clk = 0;
    end

    trainer_scoreboard sb = new();
    int  idle_cycles;
    int  hold_off;     // cycles the result side must stay stalled
    bit  stim_done;

    initial begin
        in_ch.valid = 0;
        in_ch.command = CMD_INFER;
        in_ch.feature_a = 0;
        in_ch.feature_b = 0;
        in_ch.feature_c = 0;
        in_ch.target_value = 0;
        in_ch.param_index = 0;
        in_ch.param_value = 0;
        cfg_ch.valid = 0;
        cfg_ch.rate_shift = 0;
        res_ch.ready = 0;
    end

    // short gaps mostly, a long one now and then
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(20, 200);
    endfunction

    // offer one beat and hold it until the block takes it
    task automatic send_beat(t_beat b);
        repeat (gap_len() > 100 ? 3 : 0) @(negedge i_clk);
        in_ch.valid = 1;
        in_ch.command = b.command;
        in_ch.feature_a = b.fa;
        in_ch.feature_b = b.fb;
        in_ch.feature_c = b.fc;
        in_ch.target_value = b.target;
        in_ch.param_index = b.pidx;
        in_ch.param_value = b.pval;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_beat(b);
        @(negedge i_clk);
        in_ch.valid = 0;
    endtask

    task automatic wait_drained();
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    // rate shift is written only with the block idle
    task automatic write_rate(logic [5:0] rs);
        wait_drained();
        cfg_ch.valid = 1;
        cfg_ch.rate_shift = rs;
        do @(posedge i_clk); while (!cfg_ch.ready);
        sb.rshift = rs;
        @(negedge i_clk);
        cfg_ch.valid = 0;
    endtask

    function automatic t_beat make_beat(logic [1:0] cmd);
        t_beat b;
        b.command = cmd;
        b.fa = $urandom_range(0, 9) == 0 ? 11'($urandom) : 11'($urandom_range(0, 4) - 2);
        b.fb = $urandom_range(0, 9) == 0 ? 11'($urandom) : 11'($urandom_range(0, 4) - 2);
        b.fc = $urandom_range(0, 9) == 0 ? 11'($urandom) : 11'($urandom_range(0, 4) - 2);
        b.target = $urandom_range(0, 7) == 0 ? 16'($urandom)
                   : 16'($urandom_range(0, 20) - 4);
        b.pidx = $urandom_range(0, 15) == 0 ? 5'($urandom) : 5'($urandom_range(0, 20));
        // mostly modest weights within plus or minus one half, sometimes the whole range
        b.pval = $urandom_range(0, 5) == 0 ? 48'({$urandom, $urandom})
                 : 48'((longint'($urandom_range(0, 1 << 20)) - (1 << 19)) <<< 12);
        return b;
    endfunction

    task automatic send_cmd(logic [1:0] cmd, logic signed [10:0] a, logic signed [10:0] b2,
                            logic signed [10:0] c, logic signed [15:0] t,
                            logic [4:0] idx, logic signed [47:0] v);
        t_beat b;
        b.command = cmd;
        b.fa = a;
        b.fb = b2;
        b.fc = c;
        b.target = t;
        b.pidx = idx;
        b.pval = v;
        send_beat(b);
    endtask

    // stimulus
    initial begin
        logic [1:0] cmd;
        stim_done = 0;
        hold_off = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1;
        // directed: extreme writes, every command, ignored index, extreme features
        send_cmd(CMD_INFER, 11'sd1023, -11'sd1024, 11'sd0, 16'sd0, '0, '0);
        send_cmd(CMD_WRITE, '0, '0, '0, '0, 5'd0, 48'sh7FFF_FFFF_FFFF);
        send_cmd(CMD_WRITE, '0, '0, '0, '0, 5'd12, 48'sh8000_0000_0000);
        send_cmd(CMD_WRITE, '0, '0, '0, '0, 5'd16, 48'sh1_0000_0000);
        send_cmd(CMD_WRITE, '0, '0, '0, '0, 5'd20, 48'sh2_0000_0000);
        send_cmd(CMD_WRITE, '0, '0, '0, '0, 5'd31, 48'sh1234_5678_9ABC);
        send_cmd(CMD_WRITE, '0, '0, '0, '0, 5'd21, 48'sh1);
        send_cmd(CMD_INFER, 11'sd1023, 11'sd1023, 11'sd1023, '0, '0, '0);
        send_cmd(CMD_TRAIN, 11'sd1, 11'sd2, -11'sd1, 16'sd32767, '0, '0);
        send_cmd(CMD_TRAIN, -11'sd1024, 11'sd0, 11'sd2, -16'sd32768, '0, '0);
        send_cmd(CMD_NONE, 11'sd5, 11'sd5, 11'sd5, 16'sd5, 5'd3, 48'sd9);
        send_cmd(CMD_WRITE, '0, '0, '0, '0, 5'd11, 48'sh0_8000_0000);
        send_cmd(CMD_TRAIN, 11'sd2, 11'sd2, 11'sd2, 16'sd3, '0, '0);
        write_rate(6'd0);
        send_cmd(CMD_TRAIN, 11'sd1, 11'sd1, 11'sd1, 16'sd100, '0, '0);
        send_cmd(CMD_INFER, 11'sd1, 11'sd1, 11'sd1, '0, '0, '0);
        write_rate(6'd63);
        send_cmd(CMD_TRAIN, 11'sd1, 11'sd0, 11'sd1, -16'sd7, '0, '0);
        write_rate(6'd47);
        send_cmd(CMD_TRAIN, 11'sd2, 11'sd1, 11'sd0, 16'sd7, '0, '0);
        write_rate(6'd20);
        for (int i = 0; i < 950; i++) begin
            if (i % 190 == 189) write_rate(6'($urandom_range(0, 63)));
            // result side stops taking results, so the input backs up
            if (i == 300) hold_off = 6000;
            if (i == 600) wait_drained();     // sender waits for every result
            cmd = $urandom_range(0, 9) < 3 ? CMD_WRITE
                  : ($urandom_range(0, 1) ? CMD_TRAIN : CMD_INFER);
            if ($urandom_range(0, 40) == 0) cmd = CMD_NONE;
            send_beat(make_beat(cmd));
            repeat (gap_len()) @(negedge i_clk);
        end
        stim_done = 1;
    end

    // result side: random stalls plus one long hold-off
    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            res_ch.ready <= 0;
            hold_off <= hold_off - 1;
        end else begin
            res_ch.ready <= $urandom_range(0, 99) < 70;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready)
            sb.check_result(res_ch.prediction, res_ch.cost);
    end

    // watchdog on cycles with no beat accepted anywhere
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (res_ch.valid && res_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        idle_cycles = 0;
        sb.clear();
        wait (stim_done);
        while (sb.pending.size() != 0 && idle_cycles < 40000) @(posedge i_clk);
        if (idle_cycles >= 40000) begin
            $display("TEST FAILED");
        end else begin
            repeat (50) @(posedge i_clk);
            if (sb.errors == 0 && sb.pending.size() == 0) $display("TEST PASSED");
            else $display("TEST FAILED");
        end
        $finish;
    end

    // watchdog during stimulus
    initial begin
        wait (idle_cycles >= 40000 && !stim_done);
        $display("TEST FAILED");
        $finish;
    end
endmodule

// ----- sim.f -----
src/mrst_pkg.sv
src/mrst_ifs.sv
src/mrst_smul.sv
src/mlp_relu_sgd_trainer_unit.sv
dv/mlp_relu_sgd_trainer_unit_tb.sv
